/* hw/rtl/ceq_pkg.sv */
// Shared constants, command codes and types of the capture event queue.
`timescale 1ns / 1ps
package ceq_pkg;

	localparam int QUEUE_DEPTH = 32;
	localparam int IDX_W       = $clog2(QUEUE_DEPTH);
	localparam int STAMP_W     = 16;
	localparam int DELAY_W     = 18;
	localparam int LEN_W       = 5;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	typedef logic [IDX_W-1:0] idx_t;

	typedef enum logic [2:0] {
		CMD_LOW_EDGE  = 3'd0,
		CMD_HIGH_EDGE = 3'd1,
		CMD_ARM       = 3'd2,
		CMD_RESET     = 3'd3,
		CMD_READ_ONE  = 3'd4,
		CMD_SKIP_ONE  = 3'd5,
		CMD_PEEK_PAIR = 3'd6,
		CMD_SKIP_PAIR = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		IRQ_NONE    = 2'd0,
		IRQ_ENABLE  = 2'd1,
		IRQ_DISABLE = 2'd2
	} irq_ctl_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_DUAL_MODE       = 3'd0,
		REG_RISING_FIRST    = 3'd1,
		REG_TOGGLE_POLARITY = 3'd2,
		REG_BUFFERING       = 3'd3,
		REG_TIMEOUT_TICKS   = 3'd4,
		REG_HIGH_WATERMARK  = 3'd5
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_FIN  = 2'b10
	} state_t;

endpackage

/* hw/rtl/ceq_if.sv */
// Command and result channel interfaces of the capture event queue.
`timescale 1ns / 1ps
interface ceq_cmd_if;
	logic                        valid;
	logic                        ready;
	logic [2:0]                  cmd;
	logic [ceq_pkg::STAMP_W-1:0] capture;
	logic [ceq_pkg::STAMP_W-1:0] capture_lo;
	logic [ceq_pkg::STAMP_W-1:0] counter_now;

	modport source (output valid, cmd, capture, capture_lo, counter_now, input ready);
	modport sink (input valid, cmd, capture, capture_lo, counter_now, output ready);
endinterface

interface ceq_rsp_if;
	logic                               valid;
	logic                               ready;
	logic                               wake;
	logic                               timer_start;
	logic signed [ceq_pkg::DELAY_W-1:0] timer_delay;
	logic [1:0]                         lo_irq_ctl;
	logic                               capture_level_high;
	logic                               ok;
	logic [ceq_pkg::STAMP_W-1:0]        data_a;
	logic [ceq_pkg::STAMP_W-1:0]        data_b;
	logic                               edge_high;
	logic [ceq_pkg::LEN_W-1:0]          queue_len;

	modport source (output valid, wake, timer_start, timer_delay, lo_irq_ctl,
		capture_level_high, ok, data_a, data_b, edge_high, queue_len, input ready);
	modport sink (input valid, wake, timer_start, timer_delay, lo_irq_ctl,
		capture_level_high, ok, data_a, data_b, edge_high, queue_len, output ready);
endinterface

/* hw/rtl/ceq_ram.sv */
// Generic RAM: one write port, two registered read ports.
`timescale 1ns / 1ps
module ceq_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem_q[raddr_a];
			rdata_b <= mem_q[raddr_b];
		end
	end
endmodule

/* hw/rtl/capture_event_queue_top.sv */
// Capture event queue: ring of timer stamps with edge, timeout and read commands.
//
//  channel   dir  handshake        payload
//  cmd_ch    in   valid/ready      cmd, capture, capture_lo, counter_now
//  rsp_ch    out  valid/ready      wake .. queue_len, one item per command
//  cfg       in   cfg_we           cfg_index, cfg_data
//
// Each item passes through accept (pointer update, stamp read or first write),
// then finish (registered read data, second stamp of a pair).
// A new item is taken while the previous result drains, if that result leaves this cycle.
// arst_n clears pointers, flags, config and the result valid; the stamp RAM is not cleared.
// A stalled result holds in the output register and blocks the next accept.
`timescale 1ns / 1ps
module capture_event_queue_top (
	input  logic                            clk,
	input  logic                            arst_n,
	ceq_cmd_if.sink                         cmd_ch,
	ceq_rsp_if.source                       rsp_ch,
	input  logic                            cfg_we,
	input  logic [ceq_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [ceq_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import ceq_pkg::*;

	state_t               state_q;
	idx_t                 head_q, tail_q;
	logic                 level_q, pend_q;
	logic                 dual_q, rise_q, tog_q, buf_q;
	logic [STAMP_W-1:0]   ticks_q;
	logic [LEN_W-1:0]     hwm_q;

	logic                 accept;
	cmd_t                 cmd;
	idx_t                 head_d, tail_d, nxt1, nxt2, tail_even, tail_nxt, fill_one, fill_two;
	logic                 level_d, pend_d, empty;
	logic                 wake_d, tstart_d, ok_d, edge_d, we0, pair_d, rd_d, peek_d;
	irq_ctl_t             irq_d;
	logic [DELAY_W-1:0]   delay;
	logic [STAMP_W-1:0]   wdata0;

	logic                 wake_s1, tstart_s1, ok_s1, edge_s1, rd_s1, peek_s1, pair_s1;
	irq_ctl_t             irq_s1;
	logic [DELAY_W-1:0]   delay_s1;
	idx_t                 wr2_addr_s1;
	logic [STAMP_W-1:0]   cap_s1;

	logic                 ram_we;
	idx_t                 ram_waddr;
	logic [STAMP_W-1:0]   ram_wdata, rdata_a, rdata_b;
	idx_t                 fill_now;

	logic                 ov_q, wake_q, tstart_q, level_out_q, ok_q, edge_q;
	logic [DELAY_W-1:0]   delay_q;
	logic [1:0]           irq_q;
	logic [STAMP_W-1:0]   data_a_q, data_b_q;
	logic [LEN_W-1:0]     len_q;

	assign cmd_ch.ready = (state_q == ST_IDLE) && (!ov_q || rsp_ch.ready);
	assign accept       = cmd_ch.valid && cmd_ch.ready;
	assign cmd          = cmd_t'(cmd_ch.cmd);

	assign nxt1      = head_q + idx_t'(1);
	assign nxt2      = head_q + idx_t'(2);
	assign tail_nxt  = tail_q + idx_t'(1);
	assign tail_even = tail_q & ~idx_t'(1);
	assign fill_one  = nxt1 - tail_q;
	assign fill_two  = nxt2 - tail_q;
	assign empty     = (head_q == tail_q);
	assign delay     = DELAY_W'(cmd_ch.capture) - DELAY_W'(cmd_ch.counter_now)
		+ DELAY_W'(ticks_q);

	always_comb begin
		head_d   = head_q;
		tail_d   = tail_q;
		level_d  = level_q;
		pend_d   = pend_q;
		wake_d   = 1'b0;
		tstart_d = 1'b0;
		irq_d    = IRQ_NONE;
		ok_d     = 1'b0;
		edge_d   = 1'b0;
		we0      = 1'b0;
		pair_d   = 1'b0;
		rd_d     = 1'b0;
		peek_d   = 1'b0;
		wdata0   = cmd_ch.capture;
		case (cmd)
			CMD_LOW_EDGE: begin
				if (dual_q) begin
					if (pend_q) begin
						tstart_d = 1'b1;
						pend_d   = 1'b0;
						irq_d    = IRQ_DISABLE;
					end
				end else if (nxt1 != tail_q) begin
					if (tog_q) begin
						level_d = !level_q;
					end
					we0    = 1'b1;
					head_d = nxt1;
					if (pend_q) begin
						tstart_d = 1'b1;
						pend_d   = 1'b0;
					end
					wake_d = !buf_q || (32'(fill_one) > 32'(hwm_q));
				end
			end
			CMD_HIGH_EDGE: begin
				if (dual_q) begin
					if (nxt2 == tail_even) begin
						wake_d = 1'b1;
					end else begin
						we0    = 1'b1;
						pair_d = 1'b1;
						wdata0 = cmd_ch.capture_lo;
						head_d = nxt2;
						wake_d = !buf_q || (32'(fill_two) > 32'(hwm_q));
					end
				end
			end
			CMD_ARM: begin
				if (empty) begin
					pend_d = 1'b1;
					ok_d   = 1'b1;
					if (dual_q) begin
						irq_d = IRQ_ENABLE;
					end
				end
			end
			CMD_RESET: begin
				if (!dual_q) begin
					level_d = !rise_q;
				end
				head_d = '0;
				tail_d = '0;
			end
			CMD_READ_ONE: begin
				if (!empty) begin
					ok_d   = 1'b1;
					rd_d   = 1'b1;
					edge_d = !tail_q[0];
					tail_d = tail_nxt;
				end
			end
			CMD_SKIP_ONE: begin
				tail_d = tail_nxt;
			end
			CMD_PEEK_PAIR: begin
				if (!empty) begin
					ok_d   = 1'b1;
					rd_d   = 1'b1;
					peek_d = 1'b1;
				end
			end
			CMD_SKIP_PAIR: begin
				tail_d = tail_q + idx_t'(2);
			end
			default: begin
			end
		endcase
	end

	assign ram_we    = (accept && we0) || ((state_q == ST_FIN) && pair_s1);
	assign ram_waddr = (state_q == ST_FIN) ? wr2_addr_s1 : head_q;
	assign ram_wdata = (state_q == ST_FIN) ? cap_s1 : wdata0;

	ceq_ram #(
		.WIDTH(STAMP_W),
		.DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk    (clk),
		.we     (ram_we),
		.waddr  (ram_waddr),
		.wdata  (ram_wdata),
		.re     (accept),
		.raddr_a(tail_q),
		.raddr_b(tail_nxt),
		.rdata_a(rdata_a),
		.rdata_b(rdata_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dual_q  <= 1'b0;
			rise_q  <= 1'b1;
			tog_q   <= 1'b0;
			buf_q   <= 1'b0;
			ticks_q <= '0;
			hwm_q   <= LEN_W'(24);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_DUAL_MODE:       dual_q  <= cfg_data[0];
				REG_RISING_FIRST:    rise_q  <= cfg_data[0];
				REG_TOGGLE_POLARITY: tog_q   <= cfg_data[0];
				REG_BUFFERING:       buf_q   <= cfg_data[0];
				REG_TIMEOUT_TICKS:   ticks_q <= cfg_data[STAMP_W-1:0];
				REG_HIGH_WATERMARK:  hwm_q   <= cfg_data[LEN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			level_q <= 1'b0;
			pend_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						head_q  <= head_d;
						tail_q  <= tail_d;
						level_q <= level_d;
						pend_q  <= pend_d;
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			wake_s1     <= wake_d;
			tstart_s1   <= tstart_d;
			delay_s1    <= tstart_d ? delay : '0;
			irq_s1      <= irq_d;
			ok_s1       <= ok_d;
			edge_s1     <= edge_d;
			rd_s1       <= rd_d;
			peek_s1     <= peek_d;
			pair_s1     <= pair_d;
			wr2_addr_s1 <= nxt1;
			cap_s1      <= cmd_ch.capture;
		end
	end

	assign fill_now = head_q - tail_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (state_q == ST_FIN) begin
			ov_q <= 1'b1;
		end else if (rsp_ch.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN) begin
			wake_q      <= wake_s1;
			tstart_q    <= tstart_s1;
			delay_q     <= delay_s1;
			irq_q       <= irq_s1;
			level_out_q <= level_q;
			ok_q        <= ok_s1;
			edge_q      <= edge_s1;
			data_a_q    <= rd_s1 ? rdata_a : '0;
			data_b_q    <= peek_s1 ? rdata_b : '0;
			len_q       <= LEN_W'(fill_now);
		end
	end

	assign rsp_ch.valid              = ov_q;
	assign rsp_ch.wake               = wake_q;
	assign rsp_ch.timer_start        = tstart_q;
	assign rsp_ch.timer_delay        = signed'(delay_q);
	assign rsp_ch.lo_irq_ctl         = irq_q;
	assign rsp_ch.capture_level_high = level_out_q;
	assign rsp_ch.ok                 = ok_q;
	assign rsp_ch.data_a             = data_a_q;
	assign rsp_ch.data_b             = data_b_q;
	assign rsp_ch.edge_high          = edge_q;
	assign rsp_ch.queue_len          = len_q;

	a_no_accept_in_fin: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIN |-> !cmd_ch.ready)
		else $error("item accepted while previous item unfinished");

	a_result_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIN |-> !ov_q)
		else $error("result register occupied at finish");

	a_accept_to_fin: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_FIN && ov_q == 1'b0)
		else $error("accepted item did not move to finish");

	a_data_needs_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_ch.valid && !rsp_ch.ok |-> rsp_ch.data_a == '0 && rsp_ch.data_b == '0)
		else $error("stamp data without ok");

	a_delay_needs_start: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_ch.valid && !rsp_ch.timer_start |-> rsp_ch.timer_delay == '0)
		else $error("timer delay without timer start");
endmodule

/* test/capture_queue_checker.sv */
// Checker for the capture event queue: predicts each result from accepted commands and compares.
`timescale 1ns / 1ps
module capture_queue_checker
	import ceq_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	ceq_cmd_if                     cmd_ch,
	ceq_rsp_if                     rsp_ch,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output int                     errors,
	output int                     pending,
	output int                     checked
);

	localparam int MAX_REPORTS = 40;

	typedef struct packed {
		logic                      wake;
		logic                      timer_start;
		logic signed [DELAY_W-1:0] timer_delay;
		irq_ctl_t                  lo_irq_ctl;
		logic                      level_high;
		logic                      ok;
		logic [STAMP_W-1:0]        data_a;
		logic [STAMP_W-1:0]        data_b;
		logic                      edge_high;
		logic [LEN_W-1:0]          queue_len;
	} capture_result_t;

	logic [STAMP_W-1:0] stamp_mem [QUEUE_DEPTH];
	idx_t               wr_ptr;
	idx_t               rd_ptr;
	logic               level_flag;
	logic               timeout_armed;
	logic               cfg_dual;
	logic               cfg_rising;
	logic               cfg_toggle;
	logic               cfg_buffer;
	logic [STAMP_W-1:0] cfg_timeout;
	logic [LEN_W-1:0]   cfg_watermark;
	capture_result_t    predicted_results [$];

	function automatic idx_t fill_level();
		return wr_ptr - rd_ptr;
	endfunction

	function automatic logic wake_due();
		idx_t fill;
		fill = fill_level();
		return !cfg_buffer || (fill > cfg_watermark);
	endfunction

	// consume the armed timeout and request the timer start
	function automatic void fire_timeout(inout capture_result_t r, input logic [STAMP_W-1:0] cap,
			input logic [STAMP_W-1:0] now);
		int span;
		span = int'(cap) - int'(now) + int'(cfg_timeout);
		timeout_armed = 1'b0;
		r.timer_start = 1'b1;
		r.timer_delay = span[DELAY_W-1:0];
	endfunction

	function automatic capture_result_t predict_capture_step(cmd_t c, logic [STAMP_W-1:0] cap,
			logic [STAMP_W-1:0] cap_lo, logic [STAMP_W-1:0] now);
		capture_result_t r;
		idx_t            nxt;
		idx_t            second;
		r = '0;
		case (c)
			CMD_LOW_EDGE: begin
				if (cfg_dual) begin
					if (timeout_armed) begin
						fire_timeout(r, cap, now);
						r.lo_irq_ctl = IRQ_DISABLE;
					end
				end else begin
					nxt = wr_ptr + idx_t'(1);
					if (nxt != rd_ptr) begin
						if (cfg_toggle)
							level_flag = !level_flag;
						stamp_mem[wr_ptr] = cap;
						wr_ptr = nxt;
						if (timeout_armed)
							fire_timeout(r, cap, now);
						r.wake = wake_due();
					end
				end
			end
			CMD_HIGH_EDGE: begin
				if (cfg_dual) begin
					nxt = wr_ptr + idx_t'(2);
					if (nxt == {rd_ptr[IDX_W-1:1], 1'b0}) begin
						r.wake = 1'b1;
					end else begin
						second = wr_ptr + idx_t'(1);
						stamp_mem[wr_ptr] = cap_lo;
						stamp_mem[second] = cap;
						wr_ptr = nxt;
						r.wake = wake_due();
					end
				end
			end
			CMD_ARM: begin
				if (wr_ptr == rd_ptr) begin
					timeout_armed = 1'b1;
					if (cfg_dual)
						r.lo_irq_ctl = IRQ_ENABLE;
					r.ok = 1'b1;
				end
			end
			CMD_RESET: begin
				if (!cfg_dual)
					level_flag = !cfg_rising;
				wr_ptr = '0;
				rd_ptr = '0;
			end
			CMD_READ_ONE: begin
				if (wr_ptr != rd_ptr) begin
					r.data_a = stamp_mem[rd_ptr];
					r.edge_high = !rd_ptr[0];
					r.ok = 1'b1;
					rd_ptr = rd_ptr + idx_t'(1);
				end
			end
			CMD_SKIP_ONE: rd_ptr = rd_ptr + idx_t'(1);
			CMD_PEEK_PAIR: begin
				if (wr_ptr != rd_ptr) begin
					second = rd_ptr + idx_t'(1);
					r.data_a = stamp_mem[rd_ptr];
					r.data_b = stamp_mem[second];
					r.ok = 1'b1;
				end
			end
			default: rd_ptr = rd_ptr + idx_t'(2);
		endcase
		r.level_high = level_flag;
		r.queue_len = fill_level();
		return r;
	endfunction

	task automatic check_field(string name, logic signed [31:0] want, logic signed [31:0] got);
		if (got !== want) begin
			errors++;
			if (errors <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		capture_result_t want;
		if (!arst_n) begin
			cfg_dual = 1'b0;
			cfg_rising = 1'b1;
			cfg_toggle = 1'b0;
			cfg_buffer = 1'b0;
			cfg_timeout = '0;
			cfg_watermark = LEN_W'(24);
			wr_ptr = '0;
			rd_ptr = '0;
			level_flag = 1'b0;
			timeout_armed = 1'b0;
			predicted_results.delete();
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_DUAL_MODE:       cfg_dual = cfg_data[0];
					REG_RISING_FIRST:    cfg_rising = cfg_data[0];
					REG_TOGGLE_POLARITY: cfg_toggle = cfg_data[0];
					REG_BUFFERING:       cfg_buffer = cfg_data[0];
					REG_TIMEOUT_TICKS:   cfg_timeout = cfg_data[STAMP_W-1:0];
					REG_HIGH_WATERMARK:  cfg_watermark = cfg_data[LEN_W-1:0];
					default: ;
				endcase
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (predicted_results.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: result item with none expected, expected nothing, actual len %0d",
							$time, rsp_ch.queue_len);
				end else begin
					want = predicted_results.pop_front();
					checked++;
					check_field("wake", want.wake, rsp_ch.wake);
					check_field("timer_start", want.timer_start, rsp_ch.timer_start);
					check_field("timer_delay", $signed(want.timer_delay), $signed(rsp_ch.timer_delay));
					check_field("lo_irq_ctl", want.lo_irq_ctl, rsp_ch.lo_irq_ctl);
					check_field("capture_level_high", want.level_high, rsp_ch.capture_level_high);
					check_field("ok", want.ok, rsp_ch.ok);
					check_field("data_a", want.data_a, rsp_ch.data_a);
					check_field("data_b", want.data_b, rsp_ch.data_b);
					check_field("edge_high", want.edge_high, rsp_ch.edge_high);
					check_field("queue_len", want.queue_len, rsp_ch.queue_len);
				end
			end
			if (cmd_ch.valid && cmd_ch.ready)
				predicted_results.push_back(predict_capture_step(cmd_t'(cmd_ch.cmd), cmd_ch.capture,
					cmd_ch.capture_lo, cmd_ch.counter_now));
			pending = predicted_results.size();
		end
	end

endmodule

/* test/tb_top.sv */
// Testbench top for the capture event queue: clock, reset, command stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;
	import ceq_pkg::*;

	localparam int    HALF_PERIOD  = 4;
	localparam int    ITEMS        = 1750;
	localparam int    PHASES       = 6;
	localparam int    QUIET_TAIL   = 250;
	localparam int    LONG_HOLD    = 60;
	localparam int    DRAIN_LIMIT  = 5000;
	localparam longint RUN_LIMIT_NS = 3200000;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	ceq_cmd_if cmd_ch ();
	ceq_rsp_if rsp_ch ();

	int errors;
	int pending;
	int checked;
	int sent;
	int directed_count;
	int settings = 1;

	bit idle_on = 1'b1;
	bit quiet = 1'b0;
	bit long_hold = 1'b0;

	idx_t                   q_head = '0;
	idx_t                   q_tail = '0;
	bit                     q_dual = 1'b0;
	bit [QUEUE_DEPTH-1:0]   stamp_written = '0;

	capture_event_queue_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_ch    (cmd_ch),
		.rsp_ch    (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	capture_queue_checker queue_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_ch    (cmd_ch),
		.rsp_ch    (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.pending   (pending),
		.checked   (checked)
	);

	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	// follow the queue pointers so that no never-written stamp gets read
	function automatic void track_item(cmd_t c);
		idx_t nxt;
		idx_t second;
		case (c)
			CMD_LOW_EDGE: begin
				nxt = q_head + idx_t'(1);
				if (!q_dual && nxt != q_tail) begin
					stamp_written[q_head] = 1'b1;
					q_head = nxt;
				end
			end
			CMD_HIGH_EDGE: begin
				nxt = q_head + idx_t'(2);
				second = q_head + idx_t'(1);
				if (q_dual && nxt != {q_tail[IDX_W-1:1], 1'b0}) begin
					stamp_written[q_head] = 1'b1;
					stamp_written[second] = 1'b1;
					q_head = nxt;
				end
			end
			CMD_RESET: begin
				q_head = '0;
				q_tail = '0;
			end
			CMD_READ_ONE: if (q_head != q_tail) q_tail = q_tail + idx_t'(1);
			CMD_SKIP_ONE: q_tail = q_tail + idx_t'(1);
			CMD_SKIP_PAIR: q_tail = q_tail + idx_t'(2);
			default: ;
		endcase
	endfunction

	function automatic bit reads_unwritten(cmd_t c);
		idx_t second;
		second = q_tail + idx_t'(1);
		if (q_head == q_tail)
			return 1'b0;
		if (c == CMD_READ_ONE)
			return !stamp_written[q_tail];
		if (c == CMD_PEEK_PAIR)
			return !stamp_written[q_tail] || !stamp_written[second];
		return 1'b0;
	endfunction

	function automatic cmd_t choose_cmd(bit filling);
		int r;
		r = $urandom_range(0, 99);
		if (r < 1) return CMD_RESET;
		if (r < 6) return CMD_ARM;
		if (r < 9) return CMD_SKIP_ONE;
		if (r < 11) return CMD_SKIP_PAIR;
		if (r < 16) return q_dual ? CMD_LOW_EDGE : CMD_HIGH_EDGE;
		if (r < (filling ? 76 : 42)) return q_dual ? CMD_HIGH_EDGE : CMD_LOW_EDGE;
		if (r < (filling ? 90 : 82)) return CMD_READ_ONE;
		return CMD_PEEK_PAIR;
	endfunction

	function automatic logic [STAMP_W-1:0] rand_stamp();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return STAMP_W'($urandom);
		endcase
	endfunction

	task automatic send_item(cmd_t c, logic [STAMP_W-1:0] cap, logic [STAMP_W-1:0] cap_lo,
			logic [STAMP_W-1:0] now);
		int gap;
		gap = 0;
		if (idle_on && !quiet && $urandom_range(0, 5) == 0)
			gap = $urandom_range(1, 4);
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		track_item(c);
		cmd_ch.valid       <= 1'b1;
		cmd_ch.cmd         <= c;
		cmd_ch.capture     <= cap;
		cmd_ch.capture_lo  <= cap_lo;
		cmd_ch.counter_now <= now;
		@(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
		sent++;
	endtask

	// drop valid and hold until every predicted result has come back or DRAIN_LIMIT runs out
	task automatic settle();
		int n;
		cmd_ch.valid <= 1'b0;
		n = 0;
		do begin
			@(negedge clk);
			n++;
		end while (pending != 0 && n < DRAIN_LIMIT);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t r, logic [CFG_DATA_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= r;
		cfg_data  <= value;
		@(posedge clk);
	endtask

	task automatic configure(bit dual, bit rising, bit toggle, bit buffer_on,
			logic [STAMP_W-1:0] timeout, logic [LEN_W-1:0] watermark);
		write_reg(REG_DUAL_MODE, CFG_DATA_W'(dual));
		write_reg(REG_RISING_FIRST, CFG_DATA_W'(rising));
		write_reg(REG_TOGGLE_POLARITY, CFG_DATA_W'(toggle));
		write_reg(REG_BUFFERING, CFG_DATA_W'(buffer_on));
		write_reg(REG_TIMEOUT_TICKS, CFG_DATA_W'(timeout));
		write_reg(REG_HIGH_WATERMARK, CFG_DATA_W'(watermark));
		cfg_we <= 1'b0;
		q_dual = dual;
		settings++;
	endtask

	initial begin : rsp_drive
		int hold;
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (long_hold) begin
				long_hold = 1'b0;
				rsp_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (idle_on && !quiet && $urandom_range(0, 5) == 0) begin
				hold = $urandom_range(1, 4);
				rsp_ch.ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			@(posedge clk);
		end
	end

	initial begin : stimulus
		cmd_t c;
		int   count;
		int   per_phase;
		int   flip_left;
		bit   filling;
		cmd_ch.valid       <= 1'b0;
		cmd_ch.cmd         <= CMD_LOW_EDGE;
		cmd_ch.capture     <= '0;
		cmd_ch.capture_lo  <= '0;
		cmd_ch.counter_now <= '0;
		cfg_we             <= 1'b0;
		cfg_index          <= REG_DUAL_MODE;
		cfg_data           <= '0;
		arst_n             <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(CMD_READ_ONE, '0, '0, '0);
		send_item(CMD_PEEK_PAIR, '0, '0, '0);
		send_item(CMD_ARM, '0, '0, '0);
		send_item(CMD_LOW_EDGE, 16'hFFFF, '0, 16'h0000);
		send_item(CMD_LOW_EDGE, 16'h0000, '0, 16'hFFFF);
		send_item(CMD_LOW_EDGE, 16'h1234, '0, 16'h5555);
		send_item(CMD_ARM, '0, '0, '0);
		send_item(CMD_HIGH_EDGE, 16'hFFFF, 16'hFFFF, '0);
		send_item(CMD_PEEK_PAIR, '0, '0, '0);
		send_item(CMD_READ_ONE, '0, '0, '0);
		send_item(CMD_READ_ONE, '0, '0, '0);
		send_item(CMD_SKIP_PAIR, '0, '0, '0);
		send_item(CMD_LOW_EDGE, 16'h8001, '0, '0);
		send_item(CMD_RESET, '0, '0, '0);
		send_item(CMD_LOW_EDGE, 16'hAAAA, '0, '0);
		send_item(CMD_PEEK_PAIR, '0, '0, '0);
		send_item(CMD_SKIP_ONE, '0, '0, '0);
		send_item(CMD_SKIP_ONE, '0, '0, '0);
		send_item(CMD_RESET, '0, '0, '0);
		settle();

		configure(1'b1, 1'b0, 1'b1, 1'b1, 16'hFFFF, '0);
		send_item(CMD_ARM, '0, '0, '0);
		send_item(CMD_LOW_EDGE, 16'hFFFF, '0, 16'h0000);
		send_item(CMD_HIGH_EDGE, 16'hFFFF, 16'h0000, '0);
		send_item(CMD_SKIP_PAIR, '0, '0, '0);
		send_item(CMD_SKIP_PAIR, '0, '0, '0);
		send_item(CMD_HIGH_EDGE, 16'h5A5A, 16'hA5A5, '0);
		send_item(CMD_RESET, '0, '0, '0);
		settle();

		configure(1'b0, 1'b0, 1'b1, 1'b1, '0, 5'd31);
		send_item(CMD_RESET, '0, '0, '0);
		send_item(CMD_ARM, '0, '0, '0);
		send_item(CMD_LOW_EDGE, 16'h0000, '0, 16'hFFFF);
		send_item(CMD_LOW_EDGE, 16'h7FFF, '0, '0);
		send_item(CMD_READ_ONE, '0, '0, '0);
		settle();
		directed_count = sent;

		per_phase = ITEMS / PHASES;
		filling = 1'b1;
		flip_left = 0;
		for (int p = 0; p < PHASES; p++) begin
			configure(p % 2 == 1, 1'($urandom_range(0, 1)),
				(p == 0) ? 1'b1 : 1'($urandom_range(0, 1)),
				(p == 3 || p == 4) ? 1'b1 : 1'($urandom_range(0, 1)),
				(p == 1) ? 16'hFFFF : (p == 2) ? 16'h0000 : 16'($urandom),
				(p == 3) ? 5'd0 : (p == 4) ? 5'd31 : (p == 5) ? 5'd24
					: 5'($urandom_range(0, 31)));
			count = 0;
			while (count < per_phase) begin
				if (flip_left == 0) begin
					filling = !filling;
					flip_left = $urandom_range(24, 64);
					idle_on = $urandom_range(0, 3) != 0;
				end
				flip_left--;
				if (p == 2 && count == 100)
					long_hold = 1'b1;
				if (p == PHASES - 1 && count == per_phase - QUIET_TAIL)
					quiet = 1'b1;
				c = choose_cmd(filling);
				if (reads_unwritten(c))
					c = q_dual ? CMD_HIGH_EDGE : CMD_LOW_EDGE;
				send_item(c, rand_stamp(), rand_stamp(), rand_stamp());
				if (!(c == CMD_HIGH_EDGE && !q_dual))
					count++;
			end
			settle();
		end

		$display("Run covered %0d command items (%0d directed) over %0d register settings,",
			sent, directed_count, settings);
		$display("with full-queue drops, pointer wrap by skips and edge timeouts; %0d results compared.",
			checked);
		if (errors == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin : watchdog
		#(RUN_LIMIT_NS);
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
